>>> sv/assert_macros.svh
// Assertion macros for the sprite frame sequencer.
// Included by the RTL files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SFS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/sfs_pkg.sv
// Package for the sprite frame sequencer: codes, widths, reset values and
// the command, status and state types shared by controller and datapath.
// No dependencies.
`default_nettype none

package sfs_pkg;

    localparam int REQ_W      = 2;
    localparam int DT_W       = 16;
    localparam int TI_W       = 8;
    localparam int DUR_W      = 24;
    localparam int FRAME_W    = 8;
    localparam int CLIP_W     = 9;
    localparam int POS_W      = 10;
    localparam int IDX_W      = 10;
    localparam int ELAPSED_W  = 32;
    localparam int SPEED_W    = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_FRAME     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_TABLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAYBACK_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_Q8        = 3'd5;

    localparam logic [SPEED_W-1:0] SPEED_RESET     = 16'd256;
    localparam logic [DUR_W-1:0]   MIN_DURATION_US = 24'd1000;

    typedef struct packed {
        logic latch;
        logic write;
        logic restart;
        logic clamp;
        logic acc;
        logic look;
        logic step;
        logic mod_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             skip;
        logic             paused;
        logic             cur_out;
        logic             step_more;
        logic             mod_done;
        logic             out_busy;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACC,
        ST_LOOK,
        ST_STEP,
        ST_EMIT_START,
        ST_EMIT_WAIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> sv/sfs_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on sfs_pkg for field widths.
`default_nettype none

interface sfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [sfs_pkg::REQ_W-1:0]    req_type;
    logic [sfs_pkg::DT_W-1:0]     dt_us;
    logic [sfs_pkg::TI_W-1:0]     table_index;
    logic [sfs_pkg::DUR_W-1:0]    duration_us;

    modport source (output valid, output req_type, output dt_us, output table_index,
                    output duration_us, input ready);
    modport sink (input valid, input req_type, input dt_us, input table_index,
                  input duration_us, output ready);
endinterface

interface sfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfs_pkg::FRAME_W-1:0]   frame_index;
    logic                          visible;
    logic                          finished;
    logic                          playing;

    modport source (output valid, output frame_index, output visible, output finished,
                    output playing, input ready);
    modport sink (input valid, input frame_index, input visible, input finished,
                  input playing, output ready);
endinterface

`default_nettype wire

>>> sv/sfs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/sfs_mod.sv
// Bit-serial remainder unit: reduces a position modulo the sequence length,
// one quotient bit per cycle. Depends on sfs_pkg.
`default_nettype none

module sfs_mod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sfs_pkg::POS_W-1:0] dividend,
    input  wire logic [sfs_pkg::POS_W-1:0] divisor,
    output logic                           done,
    output logic      [sfs_pkg::POS_W-1:0] rem
);

    localparam int CW = $clog2(sfs_pkg::POS_W);

    logic                      busy_reg, busy_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [sfs_pkg::POS_W-1:0] rem_reg, rem_next;
    logic [sfs_pkg::POS_W-1:0] num_reg, num_next;
    logic [sfs_pkg::POS_W-1:0] div_reg, div_next;
    logic [sfs_pkg::POS_W:0]   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        shifted   = {rem_reg, num_reg[cnt_reg]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(sfs_pkg::POS_W - 1);
            rem_next  = '0;
            num_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = sfs_pkg::POS_W'(shifted - {1'b0, div_reg});
            end
            else
            begin
                rem_next = shifted[sfs_pkg::POS_W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        div_reg <= div_next;
    end

    assign done = !busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> sv/sfs_dp.sv
// Datapath of the sprite frame sequencer: configuration registers, playback
// state, duration table, remainder unit and result register.
// Depends on sfs_pkg, sfs_ram, sfs_mod and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfs_dp #(
    parameter int FRAME_SLOTS  = 256,
    parameter int MAX_ADVANCES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [sfs_pkg::REQ_W-1:0]       req_type,
    input  wire logic [sfs_pkg::DT_W-1:0]        dt_us,
    input  wire logic [sfs_pkg::TI_W-1:0]        table_index,
    input  wire logic [sfs_pkg::DUR_W-1:0]       duration_us,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic      [sfs_pkg::FRAME_W-1:0]     frame_index,
    output logic                                 visible,
    output logic                                 finished,
    output logic                                 playing,
    input  wire sfs_pkg::cmd_t                   cmd,
    output sfs_pkg::status_t                     status
);

    localparam int AW = $clog2(FRAME_SLOTS);
    localparam int GW = $clog2(MAX_ADVANCES + 1);

    function automatic logic [sfs_pkg::CLIP_W-1:0] frame_offset(
        input logic [sfs_pkg::MODE_W-1:0] mode,
        input logic [sfs_pkg::CLIP_W-1:0] n,
        input logic [sfs_pkg::POS_W-1:0]  pos,
        input logic [sfs_pkg::POS_W-1:0]  s,
        input logic [sfs_pkg::POS_W-1:0]  period
    );
        logic [sfs_pkg::CLIP_W-1:0] last;
        logic [sfs_pkg::POS_W-1:0]  pmin;
        logic [sfs_pkg::CLIP_W-1:0] off;
        last = n - 1'b1;
        pmin = (pos < {1'b0, last}) ? pos : {1'b0, last};
        case (mode)
            sfs_pkg::MODE_REVERSE:
            begin
                off = last - pmin[sfs_pkg::CLIP_W-1:0];
            end
            sfs_pkg::MODE_PINGPONG:
            begin
                if (n == sfs_pkg::CLIP_W'(1))
                begin
                    off = '0;
                end
                else if (s < {1'b0, n})
                begin
                    off = s[sfs_pkg::CLIP_W-1:0];
                end
                else
                begin
                    off = sfs_pkg::CLIP_W'(period - s);
                end
            end
            default:
            begin
                off = pmin[sfs_pkg::CLIP_W-1:0];
            end
        endcase
        if (n == '0)
        begin
            off = '0;
        end
        return off;
    endfunction

    // configuration
    logic [sfs_pkg::FRAME_W-1:0] first_frame_reg;
    logic [sfs_pkg::CLIP_W-1:0]  frame_count_reg;
    logic [sfs_pkg::CLIP_W-1:0]  frames_in_table_reg;
    logic [sfs_pkg::MODE_W-1:0]  mode_reg;
    logic                        loop_enable_reg;
    logic [sfs_pkg::SPEED_W-1:0] speed_reg;

    // request item
    logic [sfs_pkg::REQ_W-1:0]   req_reg;
    logic [sfs_pkg::DT_W-1:0]    dt_reg;
    logic [sfs_pkg::TI_W-1:0]    ti_reg;
    logic [sfs_pkg::DUR_W-1:0]   dur_reg;

    // playback state
    logic [sfs_pkg::POS_W-1:0]     position_reg, position_next;
    logic [sfs_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [GW-1:0]                 guard_reg, guard_next;
    logic [sfs_pkg::ELAPSED_W-1:0] prod_reg, prod_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [sfs_pkg::FRAME_W-1:0] frame_index_reg;
    logic                        visible_reg, finished_reg, playing_reg;

    logic [sfs_pkg::CLIP_W-1:0]    clip_n, table_n, off_cur, off_adv, off_emit;
    logic [sfs_pkg::POS_W-1:0]     seq_len, pos_adv, mod_rem;
    logic [sfs_pkg::POS_W:0]       pos_inc;
    logic [sfs_pkg::IDX_W-1:0]     idx_cur, idx_adv, idx_emit;
    logic                          at_end, wrap, ok_adv, emit_vis, mod_done, out_busy;
    logic [sfs_pkg::DUR_W-1:0]     dur_rd, dur_min;
    logic [sfs_pkg::ELAPSED_W-1:0] cost;
    logic [sfs_pkg::ELAPSED_W:0]   sum;
    logic                          ram_we;
    logic [AW-1:0]                 raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg     <= '0;
            frame_count_reg     <= '0;
            frames_in_table_reg <= '0;
            mode_reg            <= sfs_pkg::MODE_LOOP;
            loop_enable_reg     <= 1'b1;
            speed_reg           <= sfs_pkg::SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfs_pkg::REG_FIRST_FRAME:
                    first_frame_reg <= cfg_data[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_FRAME_COUNT:
                    frame_count_reg <= cfg_data[sfs_pkg::CLIP_W-1:0];
                sfs_pkg::REG_FRAMES_IN_TABLE:
                    frames_in_table_reg <= cfg_data[sfs_pkg::CLIP_W-1:0];
                sfs_pkg::REG_PLAYBACK_MODE:
                    mode_reg <= cfg_data[sfs_pkg::MODE_W-1:0];
                sfs_pkg::REG_LOOP_ENABLE:
                    loop_enable_reg <= cfg_data[0];
                sfs_pkg::REG_SPEED_Q8:
                    speed_reg <= cfg_data[sfs_pkg::SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            dt_reg  <= dt_us;
            ti_reg  <= table_index;
            dur_reg <= duration_us;
        end
    end

    always_comb
    begin
        clip_n  = (int'(frame_count_reg) > FRAME_SLOTS) ?
                  sfs_pkg::CLIP_W'(FRAME_SLOTS) : frame_count_reg;
        table_n = (int'(frames_in_table_reg) > FRAME_SLOTS) ?
                  sfs_pkg::CLIP_W'(FRAME_SLOTS) : frames_in_table_reg;
        seq_len = (mode_reg == sfs_pkg::MODE_PINGPONG && clip_n > sfs_pkg::CLIP_W'(1)) ?
                  sfs_pkg::POS_W'({clip_n, 1'b0} - sfs_pkg::POS_W'(2)) :
                  sfs_pkg::POS_W'(clip_n);
        wrap    = loop_enable_reg && (mode_reg != sfs_pkg::MODE_ONCE);

        pos_inc = sfs_pkg::POS_W'(1) + (sfs_pkg::POS_W + 1)'(position_reg);
        at_end  = !(pos_inc < (sfs_pkg::POS_W + 1)'(seq_len));
        pos_adv = at_end ? '0 : pos_inc[sfs_pkg::POS_W-1:0];

        off_cur  = frame_offset(mode_reg, clip_n, position_reg, position_reg, seq_len);
        off_adv  = frame_offset(mode_reg, clip_n, pos_adv, pos_adv, seq_len);
        off_emit = frame_offset(mode_reg, clip_n, position_reg, mod_rem, seq_len);
        idx_cur  = sfs_pkg::IDX_W'(first_frame_reg) + sfs_pkg::IDX_W'(off_cur);
        idx_adv  = sfs_pkg::IDX_W'(first_frame_reg) + sfs_pkg::IDX_W'(off_adv);
        idx_emit = sfs_pkg::IDX_W'(first_frame_reg) + sfs_pkg::IDX_W'(off_emit);
        emit_vis = (clip_n != '0) && (idx_emit < sfs_pkg::IDX_W'(table_n));

        dur_min = (dur_rd < sfs_pkg::MIN_DURATION_US) ? sfs_pkg::MIN_DURATION_US : dur_rd;
        cost    = {dur_min, 8'b0};
        ok_adv  = elapsed_reg >= cost;
        sum     = (sfs_pkg::ELAPSED_W + 1)'(elapsed_reg) + (sfs_pkg::ELAPSED_W + 1)'(prod_reg);

        ram_we  = cmd.write && (int'(ti_reg) < FRAME_SLOTS);
        raddr   = cmd.look ? AW'(idx_cur) : AW'(idx_adv);
    end

    sfs_ram #(
        .WIDTH (sfs_pkg::DUR_W),
        .DEPTH (FRAME_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(ti_reg)),
        .wdata (dur_reg),
        .raddr (raddr),
        .rdata (dur_rd)
    );

    sfs_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (position_reg),
        .divisor  (seq_len),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        position_next = position_reg;
        elapsed_next  = elapsed_reg;
        running_next  = running_reg;
        done_next     = done_reg;
        guard_next    = guard_reg;
        prod_next     = prod_reg;
        if (cmd.restart)
        begin
            position_next = '0;
            elapsed_next  = '0;
            running_next  = 1'b1;
            done_next     = 1'b0;
        end
        if (cmd.clamp)
        begin
            if (position_reg >= seq_len)
            begin
                position_next = seq_len - 1'b1;
            end
            prod_next = sfs_pkg::ELAPSED_W'(dt_reg) * sfs_pkg::ELAPSED_W'(speed_reg);
        end
        if (cmd.acc)
        begin
            elapsed_next = sum[sfs_pkg::ELAPSED_W] ? '1 : sum[sfs_pkg::ELAPSED_W-1:0];
            guard_next   = '0;
        end
        if (cmd.step)
        begin
            guard_next = guard_reg + GW'(1);
            if (ok_adv)
            begin
                if (!at_end || wrap)
                begin
                    position_next = pos_adv;
                    elapsed_next  = elapsed_reg - cost;
                end
                else
                begin
                    position_next = seq_len - 1'b1;
                    elapsed_next  = '0;
                    done_next     = 1'b1;
                    running_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            elapsed_reg  <= '0;
            running_reg  <= 1'b1;
            done_reg     <= 1'b0;
            guard_reg    <= '0;
        end
        else
        begin
            position_reg <= position_next;
            elapsed_reg  <= elapsed_next;
            running_reg  <= running_next;
            done_reg     <= done_next;
            guard_reg    <= guard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_busy       = out_valid_reg && !out_ready;
    assign out_valid_next = cmd.load_out || out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            frame_index_reg <= emit_vis ? idx_emit[sfs_pkg::FRAME_W-1:0] : '0;
            visible_reg     <= emit_vis;
            finished_reg    <= done_reg;
            playing_reg     <= running_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_index_reg;
    assign visible     = visible_reg;
    assign finished    = finished_reg;
    assign playing     = playing_reg;

    always_comb
    begin
        status.req       = req_reg;
        status.skip      = (clip_n == '0) || ({1'b0, first_frame_reg} >= table_n);
        status.paused    = !running_reg || done_reg || (speed_reg == '0);
        status.cur_out   = !(idx_cur < sfs_pkg::IDX_W'(table_n));
        status.step_more = ok_adv && (!at_end || wrap)
                           && (guard_reg != GW'(MAX_ADVANCES - 1))
                           && (idx_adv < sfs_pkg::IDX_W'(table_n));
        status.mod_done  = mod_done;
        status.out_busy  = out_busy;
    end

    `SFS_ASSERT(a_done_stops_play, clk, rst_n, done_reg |-> !running_reg, "finished while running")
    `SFS_ASSERT(a_finish_clears, clk, rst_n, $rose(done_reg) |-> (elapsed_reg == '0), "elapsed kept at end")
    `SFS_ASSERT(a_step_in_seq, clk, rst_n, cmd.step |=> (position_reg < seq_len), "position past sequence")
    `SFS_ASSERT_NEVER(a_load_over, clk, rst_n, cmd.load_out && out_busy, "result overwritten")

endmodule

`default_nettype wire

>>> sv/sfs_ctrl.sv
// Controller of the sprite frame sequencer: sequences decode, accumulate,
// frame advances, remainder and result load. Depends on sfs_pkg.
`default_nettype none

module sfs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sfs_pkg::status_t status,
    output sfs_pkg::cmd_t         cmd
);

    sfs_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfs_pkg::ST_DECODE;
                end
            end
            sfs_pkg::ST_DECODE:
            begin
                if (status.req == sfs_pkg::REQ_TICK && !status.skip && !status.paused)
                begin
                    state_next = sfs_pkg::ST_ACC;
                end
                else
                begin
                    state_next = sfs_pkg::ST_EMIT_START;
                end
            end
            sfs_pkg::ST_ACC:
            begin
                state_next = sfs_pkg::ST_LOOK;
            end
            sfs_pkg::ST_LOOK:
            begin
                state_next = status.cur_out ? sfs_pkg::ST_EMIT_START : sfs_pkg::ST_STEP;
            end
            sfs_pkg::ST_STEP:
            begin
                if (!status.step_more)
                begin
                    state_next = sfs_pkg::ST_EMIT_START;
                end
            end
            sfs_pkg::ST_EMIT_START:
            begin
                state_next = sfs_pkg::ST_EMIT_WAIT;
            end
            sfs_pkg::ST_EMIT_WAIT:
            begin
                if (status.mod_done)
                begin
                    state_next = sfs_pkg::ST_OUT;
                end
            end
            sfs_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            sfs_pkg::ST_DECODE:
            begin
                cmd.clamp   = (status.req == sfs_pkg::REQ_TICK) && !status.skip;
                cmd.write   = (status.req == sfs_pkg::REQ_WRITE);
                cmd.restart = (status.req == sfs_pkg::REQ_RESTART);
            end
            sfs_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            sfs_pkg::ST_LOOK:
            begin
                cmd.look = 1'b1;
            end
            sfs_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
            end
            sfs_pkg::ST_EMIT_START:
            begin
                cmd.mod_start = 1'b1;
            end
            sfs_pkg::ST_EMIT_WAIT:
            begin
            end
            sfs_pkg::ST_OUT:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/sprite_frame_sequencer_top.sv
// Top level of the sprite frame sequencer: joins controller and datapath.
// Depends on sfs_pkg, sfs_if, sfs_ctrl and sfs_dp.
//
//  channel   direction  handshake     payload
//  request   in         valid/ready   req_type, dt_us, table_index, duration_us
//  result    out        valid/ready   frame_index, visible, finished, playing
//  cfg       in         cfg_we        cfg_index, cfg_data
//
// A tick advances k frames, k being at most MAX_ADVANCES: one advance per
// STEP state, bound by the duration table's read port. Duration writes,
// restarts and skipped ticks make no advance; they run only the bit-serial
// remainder for the shown frame and the result load.
// Reset is immediate; the duration table holds no reset value.
// A result waiting on result.ready does not block the next request item.
`default_nettype none

module sprite_frame_sequencer_top #(
    parameter int FRAME_SLOTS  = 256,
    parameter int MAX_ADVANCES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfs_in_if.sink                               request,
    sfs_out_if.source                            result
);

    sfs_pkg::cmd_t    cmd;
    sfs_pkg::status_t status;
    logic             in_ready;

    sfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfs_dp #(
        .FRAME_SLOTS  (FRAME_SLOTS),
        .MAX_ADVANCES (MAX_ADVANCES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (request.req_type),
        .dt_us       (request.dt_us),
        .table_index (request.table_index),
        .duration_us (request.duration_us),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .frame_index (result.frame_index),
        .visible     (result.visible),
        .finished    (result.finished),
        .playing     (result.playing),
        .cmd         (cmd),
        .status      (status)
    );

    assign request.ready = in_ready;

endmodule

`default_nettype wire
